>>> rtl/core/flux_byte_to_interval_words_core_macros.svh
// assertion macros for the flux interval converter core
`ifndef FLUX_BYTE_TO_INTERVAL_WORDS_CORE_MACROS_SVH
`define FLUX_BYTE_TO_INTERVAL_WORDS_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define FBIW_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fbiw check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define FBIW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fbiw check failed");

`endif

>>> rtl/core/fbiw_pkg.sv
// shared types and constants for the flux interval converter
`timescale 1ns / 1ps

package fbiw_pkg;

  localparam logic [7:0]  NO_FLUX_BYTE = 8'hFF;
  localparam logic [31:0] SUM_MAX      = 32'hFFFF_FFFF;
  localparam logic [23:0] COUNT_MAX    = 24'hFF_FFFF;

  typedef enum logic [1:0] {
    ALU_ADD_SAT = 2'b01,
    ALU_SUB     = 2'b10
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] lim;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] value;
    logic        over;
    logic        ge;
  } alu_res_t;

endpackage

>>> rtl/core/fbiw_alu.sv
// shared saturating adder and magnitude compare unit
`timescale 1ns / 1ps

module fbiw_alu (
  input  fbiw_pkg::alu_req_t req,
  output fbiw_pkg::alu_res_t res
);

  logic [32:0] sum;
  logic [31:0] opb;
  logic        cin;

  always_comb begin
    opb = req.b;
    cin = 1'b0;
    if (req.op == fbiw_pkg::ALU_SUB) begin
      opb = ~req.b;
      cin = 1'b1;
    end
    sum = {1'b0, req.a} + {1'b0, opb} + 33'(cin);
    // carry out of a - b means a >= b
    res.ge    = sum[32];
    res.over  = (req.op == fbiw_pkg::ALU_ADD_SAT) && (sum > {1'b0, req.lim});
    res.value = res.over ? req.lim : sum[31:0];
  end

endmodule

>>> rtl/core/flux_byte_to_interval_words_core.sv
// top level of the flux byte to interval word converter
//
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  input    | in_valid in_ready flux_byte last_byte | into core
//  output   | out_valid out_ready flux_word ...     | out of core
//  config   | cfg_write cfg_data (rev_ticks)        | into core
//
// one byte at a time; busy from the input transfer until its final result, if any, is loaded
// transition byte: accept, add, compare, sum, then an emit step for each word,
//   the single shared adder/compare unit serving add, compare, sum and each word's count bump
// 0xff byte: accept, add, finish; byte after the revolution ended: accept, finish;
//   transition ending it: accept, add, compare, finish; a summary-only result is loaded in the finish step
// a full output register stalls the core; rst is synchronous, active high, clears state, capture, config, out_valid
`timescale 1ns / 1ps

`include "flux_byte_to_interval_words_core_macros.svh"

module flux_byte_to_interval_words_core #(
  parameter int MAX_RUN_WORDS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  flux_byte,
  input  logic        last_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] flux_word,
  output logic        word_valid,
  output logic        rev_done,
  output logic [23:0] rev_word_count,
  output logic [31:0] rev_index_time,
  output logic        acc_saturated,
  output logic        last
);

  // accumulator spans MAX_RUN_WORDS * 65536 - 1 ticks
  localparam int          WHOLE_W   = $clog2(MAX_RUN_WORDS);
  localparam int          ACC_W     = WHOLE_W + 16;
  localparam logic [31:0] ACC_BOUND = 32'((MAX_RUN_WORDS * 65536) - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ADD  = 6'b000010,
    S_CMP  = 6'b000100,
    S_SUM  = 6'b001000,
    S_EMIT = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state;

  // configuration and capture state
  logic [31:0]        rev_ticks;
  logic [ACC_W-1:0]   tick_accumulator;
  logic [31:0]        tick_sum;
  logic [23:0]        word_counter;
  logic               rev_finished;
  logic               saturation_seen;

  // per-byte working registers
  logic [7:0]         byte_q;
  logic               last_q;
  logic [ACC_W-1:0]   interval;
  logic [WHOLE_W-1:0] whole_cnt;

  fbiw_pkg::alu_req_t alu_req;
  fbiw_pkg::alu_res_t alu_res;

  logic               slot_free;
  logic               out_load;
  logic [31:0]        summary_ticks;

  fbiw_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign in_ready      = (state == S_IDLE);
  assign slot_free     = !out_valid || out_ready;
  // a result enters the output register this cycle
  assign out_load      = slot_free && ((state == S_EMIT) || ((state == S_FIN) && last_q));
  assign summary_ticks = (rev_ticks != 32'd0) ? rev_ticks : tick_sum;

  // operand steering for the shared unit, one use per step
  always_comb begin
    alu_req.op  = fbiw_pkg::ALU_ADD_SAT;
    alu_req.a   = 32'd0;
    alu_req.b   = 32'd0;
    alu_req.lim = fbiw_pkg::SUM_MAX;
    case (state)
      S_ADD: begin
        alu_req.a   = 32'(tick_accumulator);
        alu_req.b   = 32'(byte_q);
        alu_req.lim = ACC_BOUND;
      end
      S_CMP: begin
        alu_req.op = fbiw_pkg::ALU_SUB;
        alu_req.a  = tick_sum;
        alu_req.b  = rev_ticks;
      end
      S_SUM: begin
        alu_req.a = tick_sum;
        alu_req.b = 32'(interval);
      end
      S_EMIT: begin
        // saturating word count bump
        alu_req.a   = 32'(word_counter);
        alu_req.b   = 32'd1;
        alu_req.lim = 32'(fbiw_pkg::COUNT_MAX);
      end
      default: begin
      end
    endcase
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      rev_ticks <= 32'd0;
    end else if (cfg_write) begin
      rev_ticks <= cfg_data;
    end
  end

  // output register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer, capture state and output payload
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      tick_accumulator <= '0;
      tick_sum         <= 32'd0;
      word_counter     <= 24'd0;
      rev_finished     <= 1'b0;
      saturation_seen  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            byte_q <= flux_byte;
            last_q <= last_byte;
            state  <= rev_finished ? S_FIN : S_ADD;
          end
        end
        S_ADD: begin
          tick_accumulator <= alu_res.value[ACC_W-1:0];
          if (alu_res.over) begin
            saturation_seen <= 1'b1;
          end
          state <= (byte_q == fbiw_pkg::NO_FLUX_BYTE) ? S_FIN : S_CMP;
        end
        S_CMP: begin
          if ((rev_ticks != 32'd0) && alu_res.ge) begin
            // revolution length reached, drop the rest of the capture
            rev_finished <= 1'b1;
            state        <= S_FIN;
          end else begin
            interval         <= (tick_accumulator != '0) ? tick_accumulator
                                                         : ACC_W'(1);
            whole_cnt        <= tick_accumulator[ACC_W-1:16];
            tick_accumulator <= '0;
            state            <= S_SUM;
          end
        end
        S_SUM: begin
          tick_sum <= alu_res.value;
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            word_valid    <= 1'b1;
            acc_saturated <= saturation_seen;
            if (whole_cnt != '0) begin
              // overflow word worth 65536 ticks
              flux_word      <= 16'd0;
              whole_cnt      <= whole_cnt - WHOLE_W'(1);
              word_counter   <= alu_res.value[23:0];
              rev_done       <= 1'b0;
              rev_word_count <= 24'd0;
              rev_index_time <= 32'd0;
              last           <= 1'b0;
            end else begin
              flux_word <= interval[15:0];
              last      <= 1'b1;
              state     <= S_IDLE;
              if (last_q) begin
                rev_done         <= 1'b1;
                rev_word_count   <= alu_res.value[23:0];
                rev_index_time   <= summary_ticks;
                tick_accumulator <= '0;
                tick_sum         <= 32'd0;
                word_counter     <= 24'd0;
                rev_finished     <= 1'b0;
                saturation_seen  <= 1'b0;
              end else begin
                rev_done       <= 1'b0;
                rev_word_count <= 24'd0;
                rev_index_time <= 32'd0;
                word_counter   <= alu_res.value[23:0];
              end
            end
          end
        end
        S_FIN: begin
          if (!last_q) begin
            state <= S_IDLE;
          end else if (slot_free) begin
            // summary with no word
            flux_word        <= 16'd0;
            word_valid       <= 1'b0;
            rev_done         <= 1'b1;
            rev_word_count   <= word_counter;
            rev_index_time   <= summary_ticks;
            acc_saturated    <= saturation_seen;
            last             <= 1'b1;
            tick_accumulator <= '0;
            tick_sum         <= 32'd0;
            word_counter     <= 24'd0;
            rev_finished     <= 1'b0;
            saturation_seen  <= 1'b0;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // summary only ever rides on the final result of a byte
  `FBIW_ASSERT_IMP(a_summary_is_last, out_valid && rev_done, last)
  // a result without a word exists only as a bare summary
  `FBIW_ASSERT_IMP(a_empty_is_summary, out_valid && !word_valid, rev_done && last)
  // one byte at a time: busy right after an input transfer
  `FBIW_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)
  // a summary transfer leaves the capture state cleared
  `FBIW_ASSERT_NEXT(a_clear_after_summary, state == S_FIN && last_q && slot_free,
                    word_counter == 24'd0 && !rev_finished && tick_sum == 32'd0)

endmodule

>>> bench/flux_byte_to_interval_words_checker.sv
// channel monitor, interval word predictor and scoreboard for the flux converter
`timescale 1ns / 1ps

module flux_byte_to_interval_words_checker #(
  parameter int MAX_RUN_WORDS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  flux_byte,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] flux_word,
  input  logic        word_valid,
  input  logic        rev_done,
  input  logic [23:0] rev_word_count,
  input  logic [31:0] rev_index_time,
  input  logic        acc_saturated,
  input  logic        last,
  output int          mismatch_count,
  output int          outstanding,
  output int          results_seen
);

  localparam logic [31:0] ACC_BOUND = 32'((MAX_RUN_WORDS << 16) - 1);

  typedef struct packed {
    logic [15:0] word;
    logic        word_valid;
    logic        rev_done;
    logic [23:0] count;
    logic [31:0] rev_time;
    logic        sat;
    logic        last;
  } interval_result_t;

  interval_result_t expected_words_q[$];

  // predictor copy of the register and the capture state
  logic [31:0] rev_ticks_copy;
  logic [31:0] tick_acc;
  logic [31:0] tick_sum;
  logic [23:0] words_emitted;
  logic        rev_over;
  logic        sat_seen;

  // newest word of the current byte, held back until we know if it is the final one
  interval_result_t held;
  logic             have_held;

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatch_count < 100)
      $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic queue_result(input interval_result_t r);
    expected_words_q.insert(expected_words_q.size(), r);
  endtask

  task automatic clear_capture();
    tick_acc      = '0;
    tick_sum      = '0;
    words_emitted = '0;
    rev_over      = 1'b0;
    sat_seen      = 1'b0;
  endtask

  task automatic emit_word(input logic [15:0] value);
    if (have_held)
      queue_result(held);
    held            = '0;
    held.word       = value;
    held.word_valid = 1'b1;
    held.sat        = sat_seen;
    have_held       = 1'b1;
    if (words_emitted != fbiw_pkg::COUNT_MAX)
      words_emitted++;
  endtask

  task automatic predict_byte(input logic [7:0] value, input logic is_last);
    logic [31:0] acc_next;
    logic [31:0] span;
    logic [32:0] wide_sum;
    int          i;
    have_held = 1'b0;
    if (!rev_over) begin
      acc_next = tick_acc + 32'(value);
      if (acc_next > ACC_BOUND) begin
        acc_next = ACC_BOUND;
        sat_seen = 1'b1;
      end
      tick_acc = acc_next;
      if (value != fbiw_pkg::NO_FLUX_BYTE) begin
        // revolution length reached: the transition is swallowed
        if (rev_ticks_copy != 0 && tick_sum >= rev_ticks_copy) begin
          rev_over = 1'b1;
        end else begin
          span     = (tick_acc != 0) ? tick_acc : 32'd1;
          tick_acc = '0;
          for (i = 0; i < span[31:16]; i++)
            emit_word(16'h0000);
          emit_word(span[15:0]);
          wide_sum = {1'b0, tick_sum} + {1'b0, span};
          tick_sum = wide_sum[32] ? fbiw_pkg::SUM_MAX : wide_sum[31:0];
        end
      end
    end
    if (is_last) begin
      if (!have_held) begin
        held      = '0;
        have_held = 1'b1;
      end
      held.rev_done = 1'b1;
      held.count    = words_emitted;
      held.rev_time = (rev_ticks_copy != 0) ? rev_ticks_copy : tick_sum;
      held.sat      = sat_seen;
      clear_capture();
    end
    if (have_held) begin
      held.last = 1'b1;
      queue_result(held);
    end
  endtask

  always @(posedge clk) begin
    interval_result_t want;
    if (rst) begin
      clear_capture();
      rev_ticks_copy = '0;
      expected_words_q.delete();
      mismatch_count = 0;
      results_seen   = 0;
    end else begin
      if (cfg_write)
        rev_ticks_copy = cfg_data;
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_words_q.size() == 0) begin
          note_mismatch("flux_word of a result nobody expected", 32'(flux_word), '0);
        end else begin
          want = expected_words_q.pop_front();
          if (flux_word != want.word)
            note_mismatch("flux_word", 32'(flux_word), 32'(want.word));
          if (word_valid != want.word_valid)
            note_mismatch("word_valid", 32'(word_valid), 32'(want.word_valid));
          if (rev_done != want.rev_done)
            note_mismatch("rev_done", 32'(rev_done), 32'(want.rev_done));
          if (rev_word_count != want.count)
            note_mismatch("rev_word_count", 32'(rev_word_count), 32'(want.count));
          if (rev_index_time != want.rev_time)
            note_mismatch("rev_index_time", rev_index_time, want.rev_time);
          if (acc_saturated != want.sat)
            note_mismatch("acc_saturated", 32'(acc_saturated), 32'(want.sat));
          if (last != want.last)
            note_mismatch("last", 32'(last), 32'(want.last));
        end
      end
      if (in_valid && in_ready)
        predict_byte(flux_byte, last_byte);
    end
    outstanding <= expected_words_q.size();
  end

endmodule

>>> bench/flux_byte_to_interval_words_core_tb.sv
// top of the flux converter bench: clock, reset, stimulus, output stalls and verdict
`timescale 1ns / 1ps

module flux_byte_to_interval_words_core_tb;

  localparam int RUN_WORDS    = 64;
  localparam int HOLD_CYCLES  = 400;   // one long output hold-off to back up the core
  localparam int DRAIN_CYCLES = 12;    // covers the core's busy states after the final word

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  flux_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] flux_word;
  logic        word_valid;
  logic        rev_done;
  logic [23:0] rev_word_count;
  logic [31:0] rev_index_time;
  logic        acc_saturated;
  logic        last;

  int mismatch_count;
  int outstanding;
  int results_seen;

  // stimulus bookkeeping
  int          bytes_sent    = 0;
  int          captures_sent = 0;
  int unsigned calm_bytes    = 0;   // remaining back-to-back bytes of a no-gap stretch

  // handshake between the stimulus and the output stall process
  logic squeeze_req  = 1'b0;
  logic squeeze_done = 1'b0;

  always #10 clk = ~clk;

  flux_byte_to_interval_words_core #(
    .MAX_RUN_WORDS(RUN_WORDS)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .flux_byte     (flux_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .flux_word     (flux_word),
    .word_valid    (word_valid),
    .rev_done      (rev_done),
    .rev_word_count(rev_word_count),
    .rev_index_time(rev_index_time),
    .acc_saturated (acc_saturated),
    .last          (last)
  );

  // watches both channels and the register port, predicts and scores every result
  flux_byte_to_interval_words_checker #(
    .MAX_RUN_WORDS(RUN_WORDS)
  ) word_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .flux_byte     (flux_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .flux_word     (flux_word),
    .word_valid    (word_valid),
    .rev_done      (rev_done),
    .rev_word_count(rev_word_count),
    .rev_index_time(rev_index_time),
    .acc_saturated (acc_saturated),
    .last          (last),
    .mismatch_count(mismatch_count),
    .outstanding   (outstanding),
    .results_seen  (results_seen)
  );

  // offer one byte and hold it until the transfer, then maybe idle a while
  // with no gap, valid stays high and the next call just swaps the payload
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    int unsigned gap;
    int unsigned roll;
    in_valid  <= 1'b1;
    flux_byte <= value;
    last_byte <= is_last;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    bytes_sent++;
    // mostly back to back, some short gaps, a few long ones
    if (calm_bytes != 0) begin
      calm_bytes--;
      gap = 0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        calm_bytes = $urandom_range(20, 60);
        gap = 0;
      end else if (roll < 60) begin
        gap = 0;
      end else if (roll < 93) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(8, 30);
      end
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // one capture of random flux bytes; the final byte carries the last flag
  // 0xff, zero and 0xfe are favored so that runs, empty intervals and the top
  // transition value come up often
  task automatic send_random_capture();
    int unsigned len;
    int unsigned roll;
    logic [7:0]  value;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
    for (int k = 0; k < len; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 25)
        value = fbiw_pkg::NO_FLUX_BYTE;
      else if (roll < 30)
        value = 8'h00;
      else if (roll < 34)
        value = 8'hFE;
      else
        value = 8'($urandom_range(0, 254));
      send_byte(value, k == len - 1);
    end
    captures_sent++;
  endtask

  // wait until every predicted word has come back and the core has gone quiet
  // the first edge lets the scoreboard count the final input transfer
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register writes happen only with the core idle
  task automatic set_rev_ticks(input logic [31:0] value);
    settle();
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // output side: random stalls, calm stretches, and one long hold-off on request
  initial begin
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned roll;
    stall_left = 0;
    calm_left  = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req && !squeeze_done) begin
        // input keeps coming while the output is blocked, so the core backs up
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        squeeze_done = 1'b1;
        out_ready <= 1'b1;
      end else if (calm_left != 0) begin
        calm_left--;
        out_ready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          calm_left = $urandom_range(30, 120);
          out_ready <= 1'b1;
        end else if (roll < 20) begin
          stall_left = $urandom_range(0, 2);
          out_ready <= 1'b0;
        end else if (roll < 22) begin
          stall_left = $urandom_range(8, 40);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // main stimulus
  initial begin
    int          phase;
    int          phase_start;
    logic [31:0] rev;

    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    flux_byte <= '0;
    last_byte <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // no truncation (register at its reset value of zero)
    // empty interval becomes 1, small values, 0xff run folded into the next word,
    // summary on the final word
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(fbiw_pkg::NO_FLUX_BYTE, 1'b0);
    send_byte(fbiw_pkg::NO_FLUX_BYTE, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h2A, 1'b1);
    captures_sent++;
    // final byte with no transition: summary alone, pending ticks dropped
    send_byte(fbiw_pkg::NO_FLUX_BYTE, 1'b0);
    send_byte(fbiw_pkg::NO_FLUX_BYTE, 1'b1);
    captures_sent++;
    // capture of a single empty interval
    send_byte(8'h00, 1'b1);
    captures_sent++;

    // shortest revolution: the first word goes out, then everything is swallowed
    set_rev_ticks(32'd1);
    send_byte(8'h05, 1'b0);
    send_byte(fbiw_pkg::NO_FLUX_BYTE, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h07, 1'b1);
    captures_sent++;

    // longest revolution: never reached
    set_rev_ticks(32'hFFFF_FFFF);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h00, 1'b1);
    captures_sent++;

    // random captures under a range of revolution lengths
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       rev = $urandom_range(1, 2000);
        1:       rev = 32'd0;
        2:       rev = $urandom_range(2000, 20000);
        3:       rev = 32'hFFFF_FFFF;
        4:       rev = 32'd1;
        default: rev = $urandom_range(100, 600);
      endcase
      set_rev_ticks(rev);
      // long output hold-off while this phase keeps sending
      if (phase == 2)
        squeeze_req <= 1'b1;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 45)
        send_random_capture();
    end

    settle();

    $display("sent %0d flux bytes in %0d captures, %0d results checked",
             bytes_sent, captures_sent, results_seen);
    $display("revolution lengths zero, one, all ones and random; %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #100_000_000;
    $display("timeout with %0d results still outstanding", outstanding);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
